@@ src/tbe_pkg.sv @@
// ----------------------------------------------------------------------------
// tbe_pkg
// shared types, constants and helpers for the keyed block transposition
// encoder
// ----------------------------------------------------------------------------
package tbe_pkg;

    localparam int MAX_KEY_LEN = 10;
    localparam int IDX_W       = 4;                 // holds 0 .. MAX_KEY_LEN
    localparam int ADDR_W      = IDX_W + 1;         // bank bit plus byte index
    localparam int MEM_DEPTH   = 1 << ADDR_W;
    localparam int LETTER_W    = 5;
    localparam int KEY_W       = LETTER_W * MAX_KEY_LEN;
    localparam int LEN_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int MIN_KEY_LEN = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LETTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR    = 2'd2;

    localparam logic [KEY_W-1:0]  KEY_LETTERS_RST = '0;
    localparam logic [LEN_W-1:0]  KEY_LENGTH_RST  = LEN_W'(MIN_KEY_LEN);
    localparam logic [BYTE_W-1:0] PAD_CHAR_RST    = 8'h20;

    // one block handed from the fill side to the emitter
    typedef struct packed {
        logic             bank;
        logic [IDX_W-1:0] cnt;    // bytes really stored in the block
        logic             last;   // block ends the message
    } tbe_job_t;

    typedef logic [MAX_KEY_LEN-1:0][IDX_W-1:0] tbe_perm_t;

    // block length clamped to the supported range
    function automatic logic [IDX_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [IDX_W-1:0] n;
        n = IDX_W'(len);
        if (len < LEN_W'(MIN_KEY_LEN))
            n = IDX_W'(MIN_KEY_LEN);
        else if (len > LEN_W'(MAX_KEY_LEN))
            n = IDX_W'(MAX_KEY_LEN);
        return n;
    endfunction

endpackage

@@ src/tbe_buf_mem.sv @@
// ----------------------------------------------------------------------------
// tbe_buf_mem
// two-bank block buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module tbe_buf_mem (
    input  logic                       clk,
    input  logic                       we,
    input  logic [tbe_pkg::ADDR_W-1:0] waddr,
    input  logic [tbe_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [tbe_pkg::ADDR_W-1:0] raddr,
    output logic [tbe_pkg::BYTE_W-1:0] rdata
);

    logic [tbe_pkg::BYTE_W-1:0] mem_reg [tbe_pkg::MEM_DEPTH];
    logic [tbe_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read data held while the read enable is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tbe_perm_gen.sv @@
// ----------------------------------------------------------------------------
// tbe_perm_gen
// builds the column order from the key, one position per cycle
// ----------------------------------------------------------------------------
module tbe_perm_gen (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rebuild,
    input  logic [tbe_pkg::KEY_W-1:0]    key_letters,
    input  logic [tbe_pkg::IDX_W-1:0]    blk_len,
    output logic                         busy,
    output tbe_pkg::tbe_perm_t           perm
);

    typedef enum logic {
        ST_IDLE,
        ST_BUILD
    } state_t;

    state_t                    state_reg;
    logic [tbe_pkg::IDX_W-1:0] idx_reg;
    tbe_pkg::tbe_perm_t        perm_reg;

    logic [tbe_pkg::LETTER_W-1:0] cur_letter;
    logic [tbe_pkg::IDX_W-1:0]    le_cnt;

    // count of the first blk_len key letters at or below the current one
    always_comb
    begin
        logic [tbe_pkg::LETTER_W-1:0] lk;
        cur_letter = '0;
        le_cnt     = '0;
        for (int k = 0; k < tbe_pkg::MAX_KEY_LEN; k++)
        begin
            if (idx_reg == tbe_pkg::IDX_W'(k))
                cur_letter = key_letters[k*tbe_pkg::LETTER_W +: tbe_pkg::LETTER_W];
        end
        for (int k = 0; k < tbe_pkg::MAX_KEY_LEN; k++)
        begin
            lk = key_letters[k*tbe_pkg::LETTER_W +: tbe_pkg::LETTER_W];
            if ((tbe_pkg::IDX_W'(k) < blk_len) && (lk <= cur_letter))
                le_cnt = le_cnt + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BUILD;
            idx_reg   <= '0;
        end
        else
        begin
            if (rebuild)
            begin
                state_reg <= ST_BUILD;
                idx_reg   <= '0;
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        idx_reg <= '0;
                    end
                    ST_BUILD:
                    begin
                        if (idx_reg == blk_len - 1'b1)
                        begin
                            state_reg <= ST_IDLE;
                            idx_reg   <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                        idx_reg   <= '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < tbe_pkg::MAX_KEY_LEN; j++)
        begin
            if ((state_reg == ST_BUILD) && !rebuild && (idx_reg == tbe_pkg::IDX_W'(j)))
                perm_reg[j] <= le_cnt - 1'b1;
        end
    end

    assign busy = (state_reg == ST_BUILD);
    assign perm = perm_reg;

endmodule

@@ src/tbe_emitter.sv @@
// ----------------------------------------------------------------------------
// tbe_emitter
// reads a finished block back in key order and drives the result stream
// ----------------------------------------------------------------------------
module tbe_emitter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  tbe_pkg::tbe_job_t          push_job,
    output logic                       slot_free,
    input  logic [tbe_pkg::IDX_W-1:0]  blk_len,
    input  logic [tbe_pkg::BYTE_W-1:0] pad_char,
    input  tbe_pkg::tbe_perm_t         perm,
    output logic                       rd_en,
    output logic [tbe_pkg::ADDR_W-1:0] rd_addr,
    input  logic [tbe_pkg::BYTE_W-1:0] rd_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tbe_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last
);

    logic                      cur_valid_reg, cur_valid_next;
    tbe_pkg::tbe_job_t         cur_job_reg, cur_job_next;
    logic                      pend_valid_reg, pend_valid_next;
    tbe_pkg::tbe_job_t         pend_job_reg, pend_job_next;
    logic [tbe_pkg::IDX_W-1:0] j_reg, j_next;
    logic                      s1_valid_reg;
    logic                      s1_pad_reg;
    logic                      s1_last_reg;
    logic                      o_valid_reg;
    logic [tbe_pkg::BYTE_W-1:0] o_byte_reg;
    logic                      o_last_reg;

    logic                      out_free;
    logic                      issue;
    logic                      last_j;
    logic                      cur_free;
    logic [tbe_pkg::IDX_W-1:0] src;

    assign out_free = !o_valid_reg || out_ready;
    assign issue    = cur_valid_reg && (!s1_valid_reg || out_free);
    assign last_j   = (j_reg == blk_len - 1'b1);
    assign cur_free = !cur_valid_reg || (issue && last_j);

    always_comb
    begin
        src = '0;
        for (int j = 0; j < tbe_pkg::MAX_KEY_LEN; j++)
        begin
            if (j_reg == tbe_pkg::IDX_W'(j))
                src = perm[j];
        end
    end

    // one pending block behind the one being read out
    always_comb
    begin
        cur_valid_next  = cur_valid_reg;
        cur_job_next    = cur_job_reg;
        pend_valid_next = pend_valid_reg;
        pend_job_next   = pend_job_reg;
        j_next          = j_reg;
        if (issue)
            j_next = last_j ? '0 : j_reg + 1'b1;
        if (cur_free)
        begin
            j_next = '0;
            if (pend_valid_reg)
            begin
                cur_valid_next  = 1'b1;
                cur_job_next    = pend_job_reg;
                pend_valid_next = 1'b0;
            end
            else if (push)
            begin
                cur_valid_next = 1'b1;
                cur_job_next   = push_job;
            end
            else
            begin
                cur_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            pend_valid_next = 1'b1;
            pend_job_next   = push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            j_reg          <= '0;
            s1_valid_reg   <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            pend_valid_reg <= pend_valid_next;
            j_reg          <= j_next;
            if (issue)
                s1_valid_reg <= 1'b1;
            else if (out_free)
                s1_valid_reg <= 1'b0;
            if (out_free)
                o_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg  <= cur_job_next;
        pend_job_reg <= pend_job_next;
        if (issue)
        begin
            s1_pad_reg  <= (src >= cur_job_reg.cnt);
            s1_last_reg <= cur_job_reg.last && last_j;
        end
        if (out_free)
        begin
            o_byte_reg <= s1_pad_reg ? pad_char : rd_data;
            o_last_reg <= s1_last_reg;
        end
    end

    assign slot_free = !pend_valid_reg;
    assign rd_en     = issue;
    assign rd_addr   = {cur_job_reg.bank, src};
    assign out_valid = o_valid_reg;
    assign out_byte  = o_byte_reg;
    assign out_last  = o_last_reg;

endmodule

@@ src/keyed_block_transposition_encoder_top.sv @@
// ----------------------------------------------------------------------------
// keyed_block_transposition_encoder_top
// block transposition encoder: bytes are grouped by key length and sent out
// in the column order that the key letters give
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one request per message byte; s_tuser marks whether s_tdata
//   carries a byte, s_tlast ends the message (pads and flushes a part block)
//   m_* channel: one request per output byte, m_tlast on the final byte
//   cfg_*: key letters, key length and pad byte, written while idle only
// throughput and output path
//   one input request per cycle while s_tready is high; a full block is
//   read back from the buffer memory through its single read port while
//   the next block fills the other bank, so one byte per cycle is sustained
//   while m_tready is high; after the request that closes a block, with the
//   read side idle, its first byte goes through the job, read and output registers
// reset and key writes
//   after reset and after every key write the column order is rebuilt, one
//   key position per cycle, with s_tready held low meanwhile
// stalls
//   a stalled m_tready holds the output register; the read pipe stops behind
//   it, and s_tready drops once a block waits behind the one being read out
// ----------------------------------------------------------------------------
module keyed_block_transposition_encoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // request in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] has_byte
    input  logic                            s_tlast,   // end_of_message
    // request out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] cipher_byte
    output logic                            m_tlast,   // last_of_message
    // configuration writes
    input  logic                            cfg_we,
    input  logic [tbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbe_pkg::KEY_W-1:0]       cfg_data
);

    logic [tbe_pkg::KEY_W-1:0]  key_letters_reg;
    logic [tbe_pkg::LEN_W-1:0]  key_length_reg;
    logic [tbe_pkg::BYTE_W-1:0] pad_char_reg;
    logic [tbe_pkg::IDX_W-1:0]  fill_reg, fill_next;
    logic                       wbank_reg, wbank_next;

    logic [tbe_pkg::IDX_W-1:0]  blk_len;
    logic                       rebuild;
    logic                       perm_busy;
    tbe_pkg::tbe_perm_t         perm;
    logic                       slot_free;
    logic                       accept;
    logic [tbe_pkg::IDX_W-1:0]  fill_inc;
    logic                       blk_full;
    logic                       push;
    tbe_pkg::tbe_job_t          push_job;
    logic                       mem_we;
    logic                       rd_en;
    logic [tbe_pkg::ADDR_W-1:0] rd_addr;
    logic [tbe_pkg::BYTE_W-1:0] rd_data;

    assign blk_len = tbe_pkg::eff_len(key_length_reg);

    // column order depends only on the letters and the length
    assign rebuild = cfg_we && ((cfg_index == tbe_pkg::CFG_KEY_LETTERS) ||
                                (cfg_index == tbe_pkg::CFG_KEY_LENGTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_letters_reg <= tbe_pkg::KEY_LETTERS_RST;
            key_length_reg  <= tbe_pkg::KEY_LENGTH_RST;
            pad_char_reg    <= tbe_pkg::PAD_CHAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbe_pkg::CFG_KEY_LETTERS: key_letters_reg <= cfg_data;
                tbe_pkg::CFG_KEY_LENGTH:  key_length_reg  <= cfg_data[tbe_pkg::LEN_W-1:0];
                tbe_pkg::CFG_PAD_CHAR:    pad_char_reg    <= cfg_data[tbe_pkg::BYTE_W-1:0];
                default:                  ;
            endcase
        end
    end

    // fill side: bytes go to the write bank, a block closes when full or at
    // end of message with anything stored
    assign s_tready = !perm_busy && slot_free;
    assign accept   = s_tvalid && s_tready;
    assign fill_inc = fill_reg + tbe_pkg::IDX_W'(s_tuser);
    assign blk_full = s_tuser && (fill_inc >= blk_len);
    assign push     = accept && (blk_full || (s_tlast && (fill_inc != '0)));
    assign mem_we   = accept && s_tuser &&
                      (fill_reg < tbe_pkg::IDX_W'(tbe_pkg::MAX_KEY_LEN));

    assign push_job.bank = wbank_reg;
    assign push_job.cnt  = fill_inc;
    assign push_job.last = s_tlast;

    always_comb
    begin
        fill_next  = fill_reg;
        wbank_next = wbank_reg;
        if (accept)
        begin
            fill_next = push ? '0 : fill_inc;
            if (push)
                wbank_next = !wbank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            wbank_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            wbank_reg <= wbank_next;
        end
    end

    tbe_perm_gen u_perm_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .rebuild     (rebuild),
        .key_letters (key_letters_reg),
        .blk_len     (blk_len),
        .busy        (perm_busy),
        .perm        (perm)
    );

    tbe_buf_mem u_buf_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr ({wbank_reg, fill_reg}),
        .wdata (s_tdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tbe_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .slot_free (slot_free),
        .blk_len   (blk_len),
        .pad_char  (pad_char_reg),
        .perm      (perm),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
